// ===== hdl/rvfp_pkg.sv =====
`timescale 1ns / 1ps
package rvfp_pkg;
    localparam logic [7:0]  START_BYTE    = 8'h01;
    localparam logic [15:0] KIND_BREATH   = 16'h0A14;
    localparam logic [15:0] KIND_HEART    = 16'h0A15;
    localparam logic [15:0] KIND_DISTANCE = 16'h0A16;
    localparam logic [15:0] KIND_PEOPLE   = 16'h0F09;
    localparam logic [15:0] KIND_TARGETS  = 16'h0A04;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNKNOWN   = 3'd1;
    localparam logic [2:0] ST_HDR_CHK   = 3'd2;
    localparam logic [2:0] ST_TOO_LONG  = 3'd3;
    localparam logic [2:0] ST_DATA_CHK  = 3'd4;

    localparam logic [3:0] PH_START    = 4'd0;
    localparam logic [3:0] PH_ID_HI    = 4'd1;
    localparam logic [3:0] PH_ID_LO    = 4'd2;
    localparam logic [3:0] PH_LEN_HI   = 4'd3;
    localparam logic [3:0] PH_LEN_LO   = 4'd4;
    localparam logic [3:0] PH_KIND_HI  = 4'd5;
    localparam logic [3:0] PH_KIND_LO  = 4'd6;
    localparam logic [3:0] PH_HDR_CHK  = 4'd7;
    localparam logic [3:0] PH_DATA     = 4'd8;
    localparam logic [3:0] PH_DATA_CHK = 4'd9;

    // frame end event from parser to record stage
    typedef struct packed {
        logic        done;
        logic [2:0]  status;
        logic [15:0] kind;
        logic [15:0] length;
        logic [63:0] head;
    } frame_evt_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] kind;
        logic [15:0] heart_rate;
        logic [15:0] breath_rate;
        logic [31:0] heart_raw;
        logic [31:0] distance_raw;
        logic [7:0]  presence;
        logic [7:0]  target_count;
        logic        changed;
        logic [31:0] good_frames;
        logic [31:0] bad_frames;
    } result_t;

    function automatic logic is_nan(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    endfunction

    function automatic logic is_zero(input logic [31:0] f);
        return f[30:0] == 31'd0;
    endfunction

    function automatic logic float_eq(input logic [31:0] a, input logic [31:0] b);
        return !is_nan(a) && !is_nan(b) && ((a == b) || (is_zero(a) && is_zero(b)));
    endfunction

    function automatic logic [15:0] float_to_i16(input logic [31:0] f);
        logic [7:0]  e;
        logic [23:0] mant;
        logic [23:0] mag;
        logic [4:0]  sh;
        e    = f[30:23];
        mant = {1'b1, f[22:0]};
        sh   = 5'(8'd150 - e);
        mag  = mant >> sh;
        if (is_nan(f) || e < 8'd127) return 16'd0;
        if (e >= 8'd142) return f[31] ? 16'h8000 : 16'h7FFF;
        return f[31] ? 16'(-mag) : mag[15:0];
    endfunction
endpackage

// ===== hdl/radar_vital_frame_parser_top.sv =====
`timescale 1ns / 1ps
// A byte that ends a frame is registered in the input byte register, and its
// result is then registered in the output register that drives m_tvalid; a
// stall can hold the byte between the two.
// Throughput: one byte per cycle; input holds while a byte is registered and
// an untaken result waits.
// Reset: synchronous active-low aresetn clears parser, record (rates -1) and
// counters; the payload head bytes are not reset.
module radar_vital_frame_parser_top import rvfp_pkg::*; #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // frame_status, frame_kind, heart_rate, breath_rate, heart_raw,
    // distance_raw, presence, target_count, record_changed, good_frames,
    // bad_frames (lowest bit up), zero fill
    output logic [199:0] m_tdata
);
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    frame_evt_t evt;
    result_t    res;
    logic       out_vld_reg;
    result_t    out_reg;
    logic       stall;

    // hold the registered byte while an untaken result waits
    assign stall    = out_vld_reg && !m_tready && in_vld_reg;
    assign s_tready = !stall;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (!stall) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall && s_tvalid) in_byte_reg <= s_tdata;
    end

    rvfp_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_vld_reg && !stall),
        .in_byte  (in_byte_reg),
        .evt      (evt)
    );

    rvfp_record u_record (
        .aclk    (aclk),
        .aresetn (aresetn),
        .evt     (evt),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (evt.done) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (evt.done) out_reg <= res;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'd0, out_reg.bad_frames, out_reg.good_frames, out_reg.changed,
                       out_reg.target_count, out_reg.presence, out_reg.distance_raw,
                       out_reg.heart_raw, out_reg.breath_rate, out_reg.heart_rate,
                       out_reg.kind, out_reg.status};
endmodule

// ===== hdl/rvfp_parser.sv =====
`timescale 1ns / 1ps
module rvfp_parser import rvfp_pkg::*; #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    output frame_evt_t evt
);
    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  hxor_reg, hxor_next;
    logic [15:0] kind_reg, kind_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  pxor_reg, pxor_next;
    logic [7:0]  head_reg [8];
    logic [15:0] pos;
    logic [15:0] kind_full;
    logic        known;

    assign pos       = len_reg - rem_reg;
    assign kind_full = {kind_reg[15:8], in_byte};
    assign known     = (kind_full == KIND_BREATH) || (kind_full == KIND_HEART) ||
                       (kind_full == KIND_DISTANCE) || (kind_full == KIND_PEOPLE) ||
                       (kind_full == KIND_TARGETS);

    always_comb begin
        phase_next = phase_reg;
        hxor_next  = hxor_reg;
        kind_next  = kind_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        pxor_next  = pxor_reg;
        evt.done   = 1'b0;
        evt.status = ST_OK;
        if (in_valid) begin
            unique case (phase_reg)
                PH_START: begin
                    if (in_byte == START_BYTE) begin
                        hxor_next  = in_byte;
                        phase_next = PH_ID_HI;
                    end
                end
                PH_ID_HI, PH_ID_LO: begin
                    hxor_next  = hxor_reg ^ in_byte;
                    phase_next = phase_reg + 4'd1;
                end
                PH_LEN_HI: begin
                    hxor_next  = hxor_reg ^ in_byte;
                    len_next   = {in_byte, 8'd0};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    hxor_next  = hxor_reg ^ in_byte;
                    len_next   = {len_reg[15:8], in_byte};
                    phase_next = PH_KIND_HI;
                end
                PH_KIND_HI: begin
                    hxor_next  = hxor_reg ^ in_byte;
                    kind_next  = {in_byte, 8'd0};
                    phase_next = PH_KIND_LO;
                end
                PH_KIND_LO: begin
                    hxor_next  = hxor_reg ^ in_byte;
                    kind_next  = kind_full;
                    if (!known) begin
                        evt.done   = 1'b1;
                        evt.status = ST_UNKNOWN;
                        phase_next = PH_START;
                    end else begin
                        phase_next = PH_HDR_CHK;
                    end
                end
                PH_HDR_CHK: begin
                    phase_next = PH_START;
                    priority if (in_byte != ~hxor_reg) begin
                        evt.done   = 1'b1;
                        evt.status = ST_HDR_CHK;
                    end else if (len_reg == 16'd0) begin
                        evt.done   = 1'b1;
                        evt.status = ST_OK;
                    end else if (32'(len_reg) > 32'(MAX_PAYLOAD)) begin
                        evt.done   = 1'b1;
                        evt.status = ST_TOO_LONG;
                    end else begin
                        rem_next   = len_reg;
                        pxor_next  = 8'd0;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    pxor_next = pxor_reg ^ in_byte;
                    rem_next  = rem_reg - 16'd1;
                    if (rem_reg == 16'd1) phase_next = PH_DATA_CHK;
                end
                PH_DATA_CHK: begin
                    evt.done   = 1'b1;
                    evt.status = (in_byte == ~pxor_reg) ? ST_OK : ST_DATA_CHK;
                    phase_next = PH_START;
                end
                default: phase_next = PH_START;
            endcase
        end
        evt.kind   = kind_next;
        evt.length = len_reg;
        // the first eight payload bytes (fewer for a shorter payload) are in the head before the check byte arrives
        for (int i = 0; i < 8; i++) begin
            evt.head[i*8 +: 8] = head_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            hxor_reg  <= 8'd0;
            kind_reg  <= 16'd0;
            len_reg   <= 16'd0;
            rem_reg   <= 16'd0;
            pxor_reg  <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            hxor_reg  <= hxor_next;
            kind_reg  <= kind_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            pxor_reg  <= pxor_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && phase_reg == PH_DATA && pos < 16'd8) begin
            head_reg[pos[2:0]] <= in_byte;
        end
    end
endmodule

// ===== hdl/rvfp_record.sv =====
`timescale 1ns / 1ps
module rvfp_record import rvfp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  frame_evt_t evt,
    output result_t    res
);
    logic [15:0] heart_int_reg, heart_int_next;
    logic [15:0] breath_int_reg, breath_int_next;
    logic [31:0] heart_bits_reg, heart_bits_next;
    logic [31:0] dist_bits_reg, dist_bits_next;
    logic [7:0]  presence_reg, presence_next;
    logic [7:0]  targets_reg, targets_next;
    logic [31:0] ok_cnt_reg, ok_cnt_next;
    logic [31:0] err_cnt_reg, err_cnt_next;
    logic        changed;
    logic [31:0] v0, v4;
    logic [15:0] t0;
    logic        good;

    assign v0   = evt.head[31:0];
    assign v4   = evt.head[63:32];
    assign t0   = float_to_i16(v0);
    assign good = evt.done && (evt.status == ST_OK);

    always_comb begin
        heart_int_next  = heart_int_reg;
        breath_int_next = breath_int_reg;
        heart_bits_next = heart_bits_reg;
        dist_bits_next  = dist_bits_reg;
        presence_next   = presence_reg;
        targets_next    = targets_reg;
        ok_cnt_next     = ok_cnt_reg;
        err_cnt_next    = err_cnt_reg;
        changed         = 1'b0;
        if (evt.done && !good) err_cnt_next = err_cnt_reg + 32'd1;
        if (good) begin
            ok_cnt_next = ok_cnt_reg + 32'd1;
            priority if (evt.kind == KIND_BREATH && evt.length >= 16'd4) begin
                if (!is_zero(v0) && t0 != breath_int_reg) begin
                    breath_int_next = t0;
                    changed = 1'b1;
                end
            end else if (evt.kind == KIND_HEART && evt.length >= 16'd4) begin
                if (!is_zero(v0)) begin
                    if (t0 != heart_int_reg) begin
                        heart_int_next = t0;
                        changed = 1'b1;
                    end
                    if (!float_eq(v0, heart_bits_reg)) begin
                        heart_bits_next = v0;
                        changed = 1'b1;
                    end
                end
            end else if (evt.kind == KIND_DISTANCE && evt.length >= 16'd8) begin
                if (v0[7:0] != 8'd0 && !float_eq(v4, dist_bits_reg)) begin
                    dist_bits_next = v4;
                    changed = 1'b1;
                end
            end else if (evt.kind == KIND_PEOPLE && evt.length >= 16'd2) begin
                if (v0[7:0] != presence_reg) begin
                    presence_next = v0[7:0];
                    changed = 1'b1;
                    if (v0[15:0] == 16'd0) begin
                        heart_int_next  = 16'd0;
                        breath_int_next = 16'd0;
                        heart_bits_next = 32'd0;
                        dist_bits_next  = 32'd0;
                    end
                end
            end else if (evt.kind == KIND_TARGETS && evt.length >= 16'd4) begin
                if (v0[7:0] != targets_reg) begin
                    targets_next = v0[7:0];
                    changed = 1'b1;
                end
            end
        end
    end

    assign res.status       = evt.status;
    assign res.kind         = evt.kind;
    assign res.heart_rate   = heart_int_next;
    assign res.breath_rate  = breath_int_next;
    assign res.heart_raw    = heart_bits_next;
    assign res.distance_raw = dist_bits_next;
    assign res.presence     = presence_next;
    assign res.target_count = targets_next;
    assign res.changed      = changed;
    assign res.good_frames  = ok_cnt_next;
    assign res.bad_frames   = err_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heart_int_reg  <= 16'hFFFF;
            breath_int_reg <= 16'hFFFF;
            heart_bits_reg <= 32'd0;
            dist_bits_reg  <= 32'd0;
            presence_reg   <= 8'd0;
            targets_reg    <= 8'd0;
            ok_cnt_reg     <= 32'd0;
            err_cnt_reg    <= 32'd0;
        end else begin
            heart_int_reg  <= heart_int_next;
            breath_int_reg <= breath_int_next;
            heart_bits_reg <= heart_bits_next;
            dist_bits_reg  <= dist_bits_next;
            presence_reg   <= presence_next;
            targets_reg    <= targets_next;
            ok_cnt_reg     <= ok_cnt_next;
            err_cnt_reg    <= err_cnt_next;
        end
    end
endmodule

// ===== dv/radar_vital_frame_parser_top_tb.sv =====
`timescale 1ns / 1ps
module radar_vital_frame_parser_top_tb;
    import rvfp_pkg::*;

    localparam int MAX_LEN = 64;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] kind;
        logic [15:0] heart_rate;
        logic [15:0] breath_rate;
        logic [31:0] heart_raw;
        logic [31:0] distance_raw;
        logic [7:0]  presence;
        logic [7:0]  target_count;
        logic        changed;
        logic [31:0] good_frames;
        logic [31:0] bad_frames;
    } frame_report_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [199:0] m_tdata;

    logic [7:0]    rx_queue[$];
    frame_report_t report_queue[$];
    int            errors = 0;
    int            cycle = 0;
    bit            took = 1'b0;

    // shadow of the parser and record
    logic [3:0]  phase;
    logic [7:0]  hdr_x, pay_x;
    logic [15:0] kind_s, len_s, left_s;
    logic [7:0]  head_s[8];
    logic [15:0] heart_s, breath_s;
    logic [31:0] heart_bits_s, dist_bits_s, ok_s, err_s;
    logic [7:0]  pres_s, targ_s;

    radar_vital_frame_parser_top #(.MAX_PAYLOAD(MAX_LEN)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic bit f_nan(logic [31:0] f);
        return f[30:23] == 8'hFF && f[22:0] != 23'd0;
    endfunction

    function automatic bit f_zero(logic [31:0] f);
        return f[30:0] == 31'd0;
    endfunction

    function automatic bit f_same(logic [31:0] a, logic [31:0] b);
        if (f_nan(a) || f_nan(b)) return 1'b0;
        return a == b || (f_zero(a) && f_zero(b));
    endfunction

    function automatic logic [15:0] f_trunc(logic [31:0] f);
        int unsigned ex;
        logic [31:0] mag;
        ex = 32'(f[30:23]);
        if (f_nan(f) || ex < 127) return 16'h0000;
        if (ex >= 142) return f[31] ? 16'h8000 : 16'h7FFF;
        mag = {8'h00, 1'b1, f[22:0]} >> (150 - ex);
        return f[31] ? 16'(0 - mag) : mag[15:0];
    endfunction

    function automatic logic [31:0] head_word(int at);
        return {head_s[at + 3], head_s[at + 2], head_s[at + 1], head_s[at]};
    endfunction

    function automatic bit update_record();
        bit ch;
        logic [31:0] v;
        logic [15:0] t;
        ch = 1'b0;
        if (kind_s == KIND_BREATH && len_s >= 16'd4) begin
            v = head_word(0);
            t = f_trunc(v);
            if (!f_zero(v) && t != breath_s) begin
                breath_s = t;
                ch = 1'b1;
            end
        end else if (kind_s == KIND_HEART && len_s >= 16'd4) begin
            v = head_word(0);
            if (!f_zero(v)) begin
                t = f_trunc(v);
                if (t != heart_s) begin
                    heart_s = t;
                    ch = 1'b1;
                end
                if (!f_same(v, heart_bits_s)) begin
                    heart_bits_s = v;
                    ch = 1'b1;
                end
            end
        end else if (kind_s == KIND_DISTANCE && len_s >= 16'd8) begin
            if (head_s[0] != 8'h00 && !f_same(head_word(4), dist_bits_s)) begin
                dist_bits_s = head_word(4);
                ch = 1'b1;
            end
        end else if (kind_s == KIND_PEOPLE && len_s >= 16'd2) begin
            if (head_s[0] != pres_s) begin
                pres_s = head_s[0];
                ch = 1'b1;
                // absence wipes the vitals
                if (head_s[0] == 8'h00 && head_s[1] == 8'h00) begin
                    heart_s = 16'h0000;
                    breath_s = 16'h0000;
                    heart_bits_s = 32'd0;
                    dist_bits_s = 32'd0;
                end
            end
        end else if (kind_s == KIND_TARGETS && len_s >= 16'd4) begin
            if (head_s[0] != targ_s) begin
                targ_s = head_s[0];
                ch = 1'b1;
            end
        end
        return ch;
    endfunction

    function automatic void close_frame(logic [2:0] st, bit ch);
        frame_report_t r;
        if (st == ST_OK) ok_s++;
        else err_s++;
        phase = PH_START;
        r.status = st;
        r.kind = kind_s;
        r.heart_rate = heart_s;
        r.breath_rate = breath_s;
        r.heart_raw = heart_bits_s;
        r.distance_raw = dist_bits_s;
        r.presence = pres_s;
        r.target_count = targ_s;
        r.changed = ch;
        r.good_frames = ok_s;
        r.bad_frames = err_s;
        report_queue.push_back(r);
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        logic [15:0] pos;
        case (phase)
            PH_START: begin
                if (b == START_BYTE) begin
                    hdr_x = b;
                    phase = PH_ID_HI;
                end
            end
            PH_ID_HI, PH_ID_LO: begin
                hdr_x ^= b;
                phase = phase + 4'd1;
            end
            PH_LEN_HI: begin
                hdr_x ^= b;
                len_s = {b, 8'h00};
                phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                hdr_x ^= b;
                len_s[7:0] = b;
                phase = PH_KIND_HI;
            end
            PH_KIND_HI: begin
                hdr_x ^= b;
                kind_s = {b, 8'h00};
                phase = PH_KIND_LO;
            end
            PH_KIND_LO: begin
                hdr_x ^= b;
                kind_s[7:0] = b;
                if (kind_s != KIND_BREATH && kind_s != KIND_HEART && kind_s != KIND_DISTANCE
                    && kind_s != KIND_PEOPLE && kind_s != KIND_TARGETS)
                    close_frame(ST_UNKNOWN, 1'b0);
                else
                    phase = PH_HDR_CHK;
            end
            PH_HDR_CHK: begin
                if (b != ~hdr_x) close_frame(ST_HDR_CHK, 1'b0);
                else if (len_s == 16'd0) close_frame(ST_OK, update_record());
                else if (len_s > MAX_LEN) close_frame(ST_TOO_LONG, 1'b0);
                else begin
                    left_s = len_s;
                    pay_x = 8'h00;
                    phase = PH_DATA;
                end
            end
            PH_DATA: begin
                pos = len_s - left_s;
                if (pos < 16'd8) head_s[pos[2:0]] = b;
                pay_x ^= b;
                left_s--;
                if (left_s == 16'd0) phase = PH_DATA_CHK;
            end
            PH_DATA_CHK: begin
                if (b == ~pay_x) close_frame(ST_OK, update_record());
                else close_frame(ST_DATA_CHK, 1'b0);
            end
            default: phase = PH_START;
        endcase
    endfunction

    function automatic logic [31:0] pick_float();
        logic [31:0] f;
        f = $urandom;
        case ($urandom_range(0, 11))
            0: f = 32'h0000_0000;
            1: f = 32'h8000_0000;
            2: f = {f[31], 8'hFF, 22'(f[21:0]), 1'b1};
            3: f = {f[31], 8'hFF, 23'd0};
            4: f[30:23] = 8'($urandom_range(142, 254));
            5: f[30:23] = 8'($urandom_range(0, 126));
            default: f[30:23] = 8'($urandom_range(127, 141));
        endcase
        return f;
    endfunction

    // queue one frame; payload bytes beyond those given are random
    task automatic queue_frame(logic [15:0] kind, logic [15:0] len, logic [7:0] data[$],
                               bit bad_hdr, bit bad_data);
        logic [7:0] hx, px, id_hi, id_lo, chk, b;
        int n;
        id_hi = 8'($urandom);
        id_lo = 8'($urandom);
        hx = START_BYTE ^ id_hi ^ id_lo ^ len[15:8] ^ len[7:0] ^ kind[15:8] ^ kind[7:0];
        chk = ~hx;
        if (bad_hdr) chk = chk ^ 8'(1 << $urandom_range(0, 7));
        rx_queue.push_back(START_BYTE);
        rx_queue.push_back(id_hi);
        rx_queue.push_back(id_lo);
        rx_queue.push_back(len[15:8]);
        rx_queue.push_back(len[7:0]);
        rx_queue.push_back(kind[15:8]);
        rx_queue.push_back(kind[7:0]);
        rx_queue.push_back(chk);
        if (len == 16'd0 || len > MAX_LEN || bad_hdr) return;
        px = 8'h00;
        for (n = 0; n < len; n++) begin
            b = (n < data.size()) ? data[n] : 8'($urandom);
            px ^= b;
            rx_queue.push_back(b);
        end
        chk = ~px;
        if (bad_data) chk = chk ^ 8'($urandom_range(1, 255));
        rx_queue.push_back(chk);
    endtask

    task automatic queue_random_frame();
        logic [7:0] data[$];
        logic [31:0] f;
        logic [15:0] kind, len;
        int sel;
        sel = $urandom_range(0, 99);
        case ($urandom_range(0, 4))
            0: kind = KIND_BREATH;
            1: kind = KIND_HEART;
            2: kind = KIND_DISTANCE;
            3: kind = KIND_PEOPLE;
            default: kind = KIND_TARGETS;
        endcase
        if (sel < 4) kind = 16'($urandom);
        len = 16'($urandom_range(0, 10));
        if ($urandom_range(0, 19) == 0) len = 16'($urandom_range(11, MAX_LEN));
        if ($urandom_range(0, 29) == 0) len = 16'($urandom_range(MAX_LEN + 1, 65535));
        f = pick_float();
        if (kind == KIND_DISTANCE) begin
            data.push_back(($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom));
            data.push_back(8'($urandom));
            data.push_back(8'($urandom));
            data.push_back(8'($urandom));
        end else if (kind == KIND_PEOPLE) begin
            f[7:0] = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 3));
            f[15:8] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
        end else if (kind == KIND_TARGETS) begin
            f[7:0] = 8'($urandom_range(0, 3));
        end
        data.push_back(f[7:0]);
        data.push_back(f[15:8]);
        data.push_back(f[23:16]);
        data.push_back(f[31:24]);
        if (kind == KIND_DISTANCE) begin
            f = pick_float();
            data[4] = f[7:0];
            data[5] = f[15:8];
            data[6] = f[23:16];
            data[7] = f[31:24];
        end
        queue_frame(kind, len, data, sel >= 4 && sel < 8, sel >= 8 && sel < 12);
        // line noise between frames
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 4)) rx_queue.push_back(8'($urandom_range(2, 255)));
    endtask

    // note the accept, then predict from the byte that was taken
    always @(posedge aclk) begin
        took = aresetn && s_tvalid && s_tready;
        if (took) predict_byte(s_tdata);
    end

    always @(negedge aclk) begin
        cycle <= cycle + 1;
        if (took) void'(rx_queue.pop_front());
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !took) begin
            s_tvalid <= 1'b1;
        end else if (rx_queue.size() > 0 &&
                     ((cycle > 600 && cycle < 1100) || $urandom_range(0, 99) >= 30)) begin
            s_tvalid <= 1'b1;
            s_tdata <= rx_queue[0];
        end else begin
            s_tvalid <= 1'b0;
        end
        m_tready <= (cycle > 1300 && cycle < 1800) || $urandom_range(0, 99) >= 30;
    end

    always @(posedge aclk) begin
        frame_report_t e;
        frame_report_t a;
        if (aresetn && m_tvalid && m_tready) begin
            a.status = m_tdata[2:0];
            a.kind = m_tdata[18:3];
            a.heart_rate = m_tdata[34:19];
            a.breath_rate = m_tdata[50:35];
            a.heart_raw = m_tdata[82:51];
            a.distance_raw = m_tdata[114:83];
            a.presence = m_tdata[122:115];
            a.target_count = m_tdata[130:123];
            a.changed = m_tdata[131];
            a.good_frames = m_tdata[163:132];
            a.bad_frames = m_tdata[195:164];
            if (report_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected frame result %p", a);
            end else begin
                e = report_queue.pop_front();
                if (a != e || m_tdata[199:196] != 4'd0) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p got %p", e, a);
                end
            end
        end
    end

    initial begin
        logic [7:0] d[$];
        phase = PH_START;
        hdr_x = 8'h00;
        pay_x = 8'h00;
        kind_s = 16'h0000;
        len_s = 16'h0000;
        left_s = 16'h0000;
        heart_s = 16'hFFFF;
        breath_s = 16'hFFFF;
        heart_bits_s = 32'd0;
        dist_bits_s = 32'd0;
        pres_s = 8'h00;
        targ_s = 8'h00;
        ok_s = 32'd0;
        err_s = 32'd0;
        foreach (head_s[i]) head_s[i] = 8'h00;

        // noise outside a frame
        rx_queue.push_back(8'h00);
        rx_queue.push_back(8'hFF);
        d = '{8'h33, 8'h33, 8'hCF, 8'h41};
        queue_frame(KIND_BREATH, 16'd4, d, 1'b0, 1'b0);
        d = '{8'h00, 8'h00, 8'h90, 8'h42};
        queue_frame(KIND_HEART, 16'd4, d, 1'b0, 1'b0);
        d = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hC0, 8'h3F};
        queue_frame(KIND_DISTANCE, 16'd8, d, 1'b0, 1'b0);
        d = '{8'h03};
        queue_frame(KIND_TARGETS, 16'd4, d, 1'b0, 1'b0);
        d = '{8'h01, 8'h00};
        queue_frame(KIND_PEOPLE, 16'd2, d, 1'b0, 1'b0);
        d = '{8'h00, 8'h00};
        queue_frame(KIND_PEOPLE, 16'd2, d, 1'b0, 1'b0);
        d = '{8'h01, 8'h00, 8'hC0, 8'h7F};
        queue_frame(KIND_HEART, 16'd4, d, 1'b0, 1'b0);
        d = '{8'h00, 8'h00, 8'h80, 8'hFF};
        queue_frame(KIND_BREATH, 16'd4, d, 1'b0, 1'b0);
        d = {};
        queue_frame(16'hFFFF, 16'd0, d, 1'b0, 1'b0);
        queue_frame(KIND_HEART, 16'd4, d, 1'b1, 1'b0);
        queue_frame(KIND_BREATH, 16'd0, d, 1'b0, 1'b0);
        queue_frame(KIND_BREATH, 16'(MAX_LEN + 1), d, 1'b0, 1'b0);
        queue_frame(KIND_TARGETS, 16'hFFFF, d, 1'b0, 1'b0);
        queue_frame(KIND_TARGETS, 16'(MAX_LEN), d, 1'b0, 1'b0);
        queue_frame(KIND_BREATH, 16'd20, d, 1'b0, 1'b0);
        queue_frame(KIND_DISTANCE, 16'd8, d, 1'b0, 1'b1);
        while (rx_queue.size() < 1750) queue_random_frame();

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        wait (rx_queue.size() == 0 && !s_tvalid);
        wait (report_queue.size() == 0);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
